// ===== rtl/stkcalc_pkg.sv =====
// stkcalc_pkg: constants, codes and types shared by the stack calculator
// used by stkcalc_req_if, stkcalc_rsp_if, stkcalc_alu and stack_calculator_alu_unit

package stkcalc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 5;
  localparam int STEP_W   = $clog2(VALUE_W);
  localparam int ADD_W    = VALUE_W + 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ARITH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic               start;
    alu_op_t            op;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic               err;
    logic [VALUE_W-1:0] result;
  } alu_rsp_t;

endpackage

// ===== rtl/stkcalc_req_if.sv =====
// stkcalc_req_if: request channel carrying one opcode and push value per transaction
// depends on stkcalc_pkg

interface stkcalc_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [stkcalc_pkg::OPCODE_W-1:0]      opcode;
  logic signed [stkcalc_pkg::VALUE_W-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// ===== rtl/stkcalc_rsp_if.sv =====
// stkcalc_rsp_if: response channel carrying status, top entry and depth per transaction
// depends on stkcalc_pkg

interface stkcalc_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic [stkcalc_pkg::STATUS_W-1:0]       status;
  logic signed [stkcalc_pkg::VALUE_W-1:0] top_value;
  logic [stkcalc_pkg::DEPTH_W-1:0]        depth;

  modport source (output valid, output status, output top_value, output depth, input ready);
  modport sink   (input valid, input status, input top_value, input depth, output ready);
endinterface

// ===== rtl/stack_calculator_alu_unit.sv =====
// stack_calculator_alu_unit: reverse-polish stack calculator top level
// depends on stkcalc_pkg, stkcalc_req_if, stkcalc_rsp_if and stkcalc_alu

// One request transaction pushes a value or applies add, subtract, multiply or divide to
// the top two entries and yields exactly one response transaction with the status, the
// new top entry (zero on an empty stack) and the new depth. The top entry sits in a
// register and the rest of the stack in a one-read, one-write memory. Push, unused
// opcodes and operations with too few entries skip the arithmetic unit; add and
// subtract use one pass of its shared adder, multiply and divide its 32 iterations,
// while a divide by zero finishes without iterating. A new request is taken once the
// previous one has finished, while its response may still be waiting in the output
// register. No clearing pass is needed after reset.

module stack_calculator_alu_unit (
  input  logic                 clk,
  input  logic                 rst,
  stkcalc_req_if.sink          req,
  stkcalc_rsp_if.source        rsp
);

  localparam int W     = stkcalc_pkg::VALUE_W;
  localparam int CNT_W = stkcalc_pkg::CNT_W;
  localparam int PTR_W = stkcalc_pkg::PTR_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_CALC  = 4'b0100,
    S_DONE  = 4'b1000
  } top_state_t;

  top_state_t                            state;
  logic [stkcalc_pkg::OPCODE_W-1:0]      op_q;
  logic [W-1:0]                          val_q;
  logic [CNT_W-1:0]                      count;
  logic [CNT_W-1:0]                      count_next;
  logic [W-1:0]                          tos;
  logic [W-1:0]                          tos_next;
  logic [W-1:0]                          rd_q;
  logic [W-1:0]                          mem [stkcalc_pkg::STACK_DEPTH];
  logic                                  we;
  logic [stkcalc_pkg::STATUS_W-1:0]      status_next;
  logic [CNT_W-1:0]                      cnt_m1;
  logic [CNT_W-1:0]                      cnt_m2;
  logic [PTR_W-1:0]                      wr_idx;
  logic [PTR_W-1:0]                      rd_idx;
  logic                                  accept;
  logic                                  out_free;
  logic                                  is_arith;
  logic                                  few;
  logic                                  full;

  logic                                  out_valid;
  logic [stkcalc_pkg::STATUS_W-1:0]      out_status;
  logic [W-1:0]                          out_top;
  logic [stkcalc_pkg::DEPTH_W-1:0]       out_depth;

  stkcalc_pkg::alu_req_t                 alu_req;
  stkcalc_pkg::alu_rsp_t                 alu_rsp;
  stkcalc_pkg::alu_op_t                  alu_op;

  assign accept   = req.valid && (state == S_IDLE);
  assign out_free = !out_valid || rsp.ready;
  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign wr_idx   = cnt_m1[PTR_W-1:0];
  assign rd_idx   = cnt_m2[PTR_W-1:0];
  assign few      = count < CNT_W'(2);
  assign full     = count == CNT_W'(stkcalc_pkg::STACK_DEPTH);
  assign is_arith = req.opcode inside {stkcalc_pkg::OP_ADD, stkcalc_pkg::OP_SUB,
                                       stkcalc_pkg::OP_MUL, stkcalc_pkg::OP_DIV};

  always_comb begin
    case (op_q)
      stkcalc_pkg::OP_ADD: alu_op = stkcalc_pkg::ALU_ADD;
      stkcalc_pkg::OP_SUB: alu_op = stkcalc_pkg::ALU_SUB;
      stkcalc_pkg::OP_MUL: alu_op = stkcalc_pkg::ALU_MUL;
      default:             alu_op = stkcalc_pkg::ALU_DIV;
    endcase
  end

  assign alu_req.start = (state == S_START);
  assign alu_req.op    = alu_op;
  assign alu_req.a     = rd_q;
  assign alu_req.b     = tos;

  stkcalc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // stack update and status for the finishing transaction
  always_comb begin
    count_next  = count;
    tos_next    = tos;
    we          = 1'b0;
    status_next = stkcalc_pkg::ST_OK;
    case (op_q)
      stkcalc_pkg::OP_PUSH: begin
        if (full) begin
          status_next = stkcalc_pkg::ST_FULL;
        end else begin
          we         = count != '0;
          tos_next   = val_q;
          count_next = count + CNT_W'(1);
        end
      end
      stkcalc_pkg::OP_ADD, stkcalc_pkg::OP_SUB, stkcalc_pkg::OP_MUL, stkcalc_pkg::OP_DIV: begin
        if (few) begin
          status_next = stkcalc_pkg::ST_FEW;
        end else if (alu_rsp.err) begin
          status_next = stkcalc_pkg::ST_ARITH;
        end else begin
          tos_next   = alu_rsp.result;
          count_next = cnt_m1;
        end
      end
      default: begin
        status_next = stkcalc_pkg::ST_OK;
      end
    endcase
  end

  // lower stack entries
  always_ff @(posedge clk) begin
    if (we && state == S_DONE && out_free) begin
      mem[wr_idx] <= tos;
    end
    rd_q <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.opcode;
            val_q <= req.push_value;
            if (is_arith && !few) begin
              state <= S_START;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_START: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (alu_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            count      <= count_next;
            tos        <= tos_next;
            out_valid  <= 1'b1;
            out_status <= status_next;
            out_top    <= (count_next != '0) ? tos_next : '0;
            out_depth  <= stkcalc_pkg::DEPTH_W'(count_next);
            state      <= S_IDLE;
          end else if (rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.top_value = out_top;
  assign rsp.depth     = out_depth;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(stkcalc_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("response raised outside the finishing state");

  a_start_operands: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> (count >= CNT_W'(2)))
    else $error("arithmetic started with fewer than two entries");
`endif

endmodule

// ===== rtl/stkcalc_alu.sv =====
// stkcalc_alu: iterative arithmetic unit around one shared 34-bit adder
// add/sub in one pass, shift-add multiply and restoring divide over 32 steps
// depends on stkcalc_pkg

module stkcalc_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  stkcalc_pkg::alu_req_t req,
  output stkcalc_pkg::alu_rsp_t rsp
);

  localparam int W  = stkcalc_pkg::VALUE_W;
  localparam int AW = stkcalc_pkg::ADD_W;

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_ADDS = 6'b000010,
    A_NEGA = 6'b000100,
    A_NEGB = 6'b001000,
    A_RUN  = 6'b010000,
    A_FIX  = 6'b100000
  } alu_state_t;

  alu_state_t                       state;
  stkcalc_pkg::alu_op_t             op_q;
  logic [W-1:0]                     a_q;
  logic [W-1:0]                     b_q;
  logic                             neg;
  logic [W-1:0]                     ma;
  logic [W-1:0]                     hi;
  logic [W-1:0]                     lo;
  logic [stkcalc_pkg::STEP_W-1:0]   step;
  logic                             done;
  logic                             err;
  logic [W-1:0]                     result;

  logic [AW-1:0] add_x;
  logic [AW-1:0] add_y;
  logic          add_sub;
  logic [AW-1:0] add_s;
  logic [W:0]    mul_t;
  logic [W:0]    div_r;
  logic          div_ge;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic          ovf;

  // shared adder operand select
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state)
      A_ADDS: begin
        add_x   = {{2{a_q[W-1]}}, a_q};
        add_y   = {{2{b_q[W-1]}}, b_q};
        add_sub = (op_q == stkcalc_pkg::ALU_SUB);
      end
      A_NEGA: begin
        add_y   = {{2{a_q[W-1]}}, a_q};
        add_sub = 1'b1;
      end
      A_NEGB: begin
        add_y   = {{2{b_q[W-1]}}, b_q};
        add_sub = 1'b1;
      end
      A_RUN: begin
        if (op_q == stkcalc_pkg::ALU_MUL) begin
          add_x = {2'b00, hi};
          add_y = {2'b00, ma};
        end else begin
          add_x   = {1'b0, div_r};
          add_y   = {2'b00, ma};
          add_sub = 1'b1;
        end
      end
      A_FIX: begin
        add_y   = {2'b00, lo};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_s  = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
  assign mul_t  = lo[0] ? add_s[W:0] : {1'b0, hi};
  assign div_r  = {hi, lo[W-1]};
  assign div_ge = ~add_s[AW-1];
  assign mag_a  = a_q[W-1] ? add_s[W-1:0] : a_q;
  assign mag_b  = b_q[W-1] ? add_s[W-1:0] : b_q;
  assign ovf    = ((op_q == stkcalc_pkg::ALU_MUL) && (hi != '0)) ||
                  (lo[W-1] && (!neg || (lo[W-2:0] != '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            a_q  <= req.a;
            b_q  <= req.b;
            op_q <= req.op;
            neg  <= req.a[W-1] ^ req.b[W-1];
            if (req.op == stkcalc_pkg::ALU_ADD || req.op == stkcalc_pkg::ALU_SUB) begin
              state <= A_ADDS;
            end else if (req.op == stkcalc_pkg::ALU_DIV && req.b == '0) begin
              done <= 1'b1;
              err  <= 1'b1;
            end else begin
              state <= A_NEGA;
            end
          end
        end
        A_ADDS: begin
          result <= add_s[W-1:0];
          err    <= add_s[W] != add_s[W-1];
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        A_NEGA: begin
          if (op_q == stkcalc_pkg::ALU_MUL) begin
            ma <= mag_a;
          end else begin
            lo <= mag_a;
          end
          state <= A_NEGB;
        end
        A_NEGB: begin
          if (op_q == stkcalc_pkg::ALU_MUL) begin
            lo <= mag_b;
          end else begin
            ma <= mag_b;
          end
          hi    <= '0;
          step  <= '0;
          state <= A_RUN;
        end
        A_RUN: begin
          if (op_q == stkcalc_pkg::ALU_MUL) begin
            hi <= mul_t[W:1];
            lo <= {mul_t[0], lo[W-1:1]};
          end else begin
            hi <= div_ge ? add_s[W-1:0] : div_r[W-1:0];
            lo <= {lo[W-2:0], div_ge};
          end
          step <= step + 1'b1;
          if (step == stkcalc_pkg::STEP_W'(W - 1)) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          result <= neg ? add_s[W-1:0] : lo;
          err    <= ovf;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.err    = err;
  assign rsp.result = result;

`ifndef ASSERT_OFF
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == A_FIX || state == A_ADDS || (state == A_IDLE && req.start)))
    else $error("alu done without a finishing step");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state != A_RUN) |-> (step == '0))
    else $error("step counter running outside the iteration");
`endif

endmodule

// ===== bench/stack_calculator_alu_unit_tb.sv =====
// stack_calculator_alu_unit_tb: self-checking bench for the rpn stack calculator
// tracks its own copy of the stack and compares every response transaction in order
// depends on stkcalc_pkg, stkcalc_req_if, stkcalc_rsp_if and stack_calculator_alu_unit

module stack_calculator_alu_unit_tb;

  localparam int OPC_W = stkcalc_pkg::OPCODE_W;
  localparam int VAL_W = stkcalc_pkg::VALUE_W;
  localparam int STS_W = stkcalc_pkg::STATUS_W;
  localparam int DEP_W = stkcalc_pkg::DEPTH_W;

  localparam logic [OPC_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OPC_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_RSVD_7 = 3'd7;

  localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_ITEMS     = 1330;
  localparam int QUIET_TAIL       = 150;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 60;
  localparam int MAX_REPORTS      = 10;

  typedef struct {
    logic [STS_W-1:0] status;
    logic [VAL_W-1:0] top_value;
    logic [DEP_W-1:0] depth;
  } calc_result_t;

  class stack_tracker;
    logic [VAL_W-1:0] entries [stkcalc_pkg::STACK_DEPTH];
    int               used;
    calc_result_t     pending_results[$];
    int               errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_request(logic [OPC_W-1:0] op, logic signed [VAL_W-1:0] value);
      calc_result_t     r;
      logic [STS_W-1:0] st;
      longint           a;
      longint           b;
      longint           full;
      st   = stkcalc_pkg::ST_OK;
      full = 0;
      if (op == stkcalc_pkg::OP_PUSH) begin
        if (used >= stkcalc_pkg::STACK_DEPTH) begin
          st = stkcalc_pkg::ST_FULL;
        end else begin
          entries[used] = value;
          used++;
        end
      end else if (op >= stkcalc_pkg::OP_ADD && op <= stkcalc_pkg::OP_DIV) begin
        if (used < 2) begin
          st = stkcalc_pkg::ST_FEW;
        end else begin
          a = longint'($signed(entries[used-2]));
          b = longint'($signed(entries[used-1]));
          case (op)
            stkcalc_pkg::OP_ADD: full = a + b;
            stkcalc_pkg::OP_SUB: full = a - b;
            stkcalc_pkg::OP_MUL: full = a * b;
            default: full = (b == 0) ? 0 : a / b;
          endcase
          if ((op == stkcalc_pkg::OP_DIV && b == 0) || full > longint'(WORD_MAX) ||
              full < longint'(WORD_MIN)) begin
            st = stkcalc_pkg::ST_ARITH;
          end else begin
            used--;
            entries[used-1] = full[VAL_W-1:0];
          end
        end
      end
      r.status    = st;
      r.top_value = (used > 0) ? entries[used-1] : '0;
      r.depth     = used[DEP_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [STS_W-1:0] status, logic [VAL_W-1:0] top_value,
                               logic [DEP_W-1:0] depth);
      calc_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("response with nothing outstanding: status %0d top %0d depth %0d",
                   status, $signed(top_value), depth);
      end else begin
        want = pending_results.pop_front();
        if (want.status !== status || want.top_value !== top_value || want.depth !== depth) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: expected status %0d top %0d depth %0d, got status %0d top %0d depth %0d",
                     want.status, $signed(want.top_value), want.depth,
                     status, $signed(top_value), depth);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  stkcalc_req_if req_ch ();
  stkcalc_rsp_if rsp_ch ();

  stack_calculator_alu_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  stack_tracker board;
  bit           sender_idle_on;
  bit           sink_stall_on;
  bit           long_hold_pending;
  int           items_sent;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #4_000_000;
    $display("stack_calculator_alu_unit test failed");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    v = '0;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom;
      2, 3: v = int'($urandom_range(0, 40)) - 20;
      4: begin
        case ($urandom_range(0, 3))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = -1;
          default: v = 1;
        endcase
      end
      5: v = int'($urandom_range(0, 131072)) - 65536;
      6: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  task automatic send_request(logic [OPC_W-1:0] op, logic signed [VAL_W-1:0] value);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.push_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(op, value);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() > 0);
  endtask

  // response side: random stalls plus one long hold-off on request
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        board.check_result(rsp_ch.status, rsp_ch.top_value, rsp_ch.depth);
      if (long_hold_pending) begin
        stall_left        = LONG_HOLD_CYCLES;
        long_hold_pending = 1'b0;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stall_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : source_side
    int  push_pct;
    int  run_len;
    int  pick;
    bit  hold_done;
    bit  pause_done;
    board             = new();
    items_sent        = 0;
    hold_done         = 1'b0;
    pause_done        = 1'b0;
    long_hold_pending = 1'b0;
    sender_idle_on    = 1'b1;
    sink_stall_on     = 1'b1;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= stkcalc_pkg::OP_PUSH;
    req_ch.push_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: too few operands, overflow in add, multiply and divide, divide by zero,
    // unused opcodes, truncation toward zero
    send_request(stkcalc_pkg::OP_ADD, 32'sd5);
    send_request(stkcalc_pkg::OP_PUSH, WORD_MIN);
    send_request(stkcalc_pkg::OP_SUB, '0);
    send_request(stkcalc_pkg::OP_PUSH, -32'sd1);
    send_request(stkcalc_pkg::OP_DIV, '0);
    send_request(stkcalc_pkg::OP_MUL, '0);
    send_request(stkcalc_pkg::OP_ADD, '0);
    send_request(stkcalc_pkg::OP_PUSH, '0);
    send_request(stkcalc_pkg::OP_DIV, '0);
    send_request(OP_RSVD_5, WORD_MAX);
    send_request(OP_RSVD_6, -32'sd1);
    send_request(OP_RSVD_7, '0);
    send_request(stkcalc_pkg::OP_SUB, '0);
    send_request(stkcalc_pkg::OP_SUB, '0);
    send_request(stkcalc_pkg::OP_PUSH, WORD_MAX);
    send_request(stkcalc_pkg::OP_PUSH, 32'sd1);
    send_request(stkcalc_pkg::OP_ADD, '0);
    send_request(stkcalc_pkg::OP_DIV, '0);
    send_request(stkcalc_pkg::OP_ADD, '0);
    send_request(stkcalc_pkg::OP_PUSH, -32'sd7);
    send_request(stkcalc_pkg::OP_PUSH, 32'sd2);
    send_request(stkcalc_pkg::OP_DIV, '0);
    send_request(stkcalc_pkg::OP_MUL, '0);

    // random runs: filling, balanced and draining phases
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= 500) begin
        long_hold_pending = 1'b1;
        hold_done         = 1'b1;
      end
      if (!pause_done && items_sent >= 900) begin
        wait_drained();
        pause_done = 1'b1;
      end
      if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
        sender_idle_on = 1'b0;
        sink_stall_on  = 1'b0;
      end else begin
        sender_idle_on = ($urandom_range(0, 2) != 0);
        sink_stall_on  = ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 25;
      endcase
      run_len = $urandom_range(8, 40);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          send_request(3'($urandom_range(OP_RSVD_5, OP_RSVD_7)), pick_value());
        else if (pick < push_pct)
          send_request(stkcalc_pkg::OP_PUSH, pick_value());
        else
          send_request(3'($urandom_range(stkcalc_pkg::OP_ADD, stkcalc_pkg::OP_DIV)),
                       pick_value());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("stack_calculator_alu_unit test passed");
    end else begin
      $display("stack_calculator_alu_unit test failed");
    end
    $finish;
  end

endmodule
